>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by lvuv_queue and lvuv_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property prop must hold at every rising edge of clk unless rst is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property prop must hold at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/lvuv_pkg.sv
package lvuv_pkg;

   localparam int DEF_WIDTH      = 512;
   localparam int DEF_HEIGHT     = 512;
   localparam int DEF_LAYERS     = 2;
   localparam int DEF_COUNT_BITS = 16;

   localparam int XY_BITS    = 9;
   localparam int LAYER_BITS = 4;
   localparam int RAY_BITS   = 7;
   localparam int COORD_BITS = 14;
   localparam int SUM_BITS   = 40;
   localparam int CODE_BITS  = 12;

   localparam logic [RAY_BITS-1:0] RAY_RESET = 7'd127;

   typedef enum logic {
      MODE_ACCUMULATE = 1'b0,
      MODE_RESOLVE    = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type                mode;
      logic                    in_frame;
      logic                    layer_ok;
      logic [XY_BITS-1:0]      pixel_x;
      logic [XY_BITS-1:0]      pixel_y;
      logic [LAYER_BITS-1:0]   layer;
      logic [RAY_BITS-1:0]     ray_level;
      logic [COORD_BITS-1:0]   coord_u;
      logic [COORD_BITS-1:0]   coord_v;
      logic [LAYER_BITS:0]     layer_count;
   } cmd_type;

   typedef struct packed {
      logic [7:0]            code_red;
      logic [7:0]            code_green;
      logic [7:0]            code_blue;
      logic [LAYER_BITS:0]   label;
      logic                  mixed;
      logic [LAYER_BITS:0]   layer_count;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_WAIT,
      ST_ACC,
      ST_SCAN,
      ST_MAJ,
      ST_DIV_U,
      ST_DIV_V,
      ST_EMIT,
      ST_WIPE
   } state_type;

endpackage

>>> hw/rtl/layer_vote_uv_map_accumulator_core.sv
// Per-pixel layer vote accumulator with coded surface-coordinate resolve.
// Channels: csr_ (one bit, map_enable), req_ (items in) and rsp_ (results out),
// all transactions complete on valid and ready high at a rising clock edge.
// req_tuser carries mode (0 accumulate, 1 resolve). An accumulate transaction
// produces no result; a resolve transaction produces exactly one.
// The front end classifies each item and registers resolves, and accumulates while
// map_enable is set; a two-entry queue feeds the back end, which owns the pixel
// memories; a kept item passes the front register, then a queue slot, to reach it.
// The back end handles one item at a time. An accumulate reads the pixel and is
// dropped or added in; a lower ray level first wipes the pixel. A resolve outside
// the frame goes straight to its result; otherwise it scans every layer, runs two
// serial divisions when a layer wins, wipes the pixel and then emits its result.
// After reset the back end sweeps all WIDTH * HEIGHT << LB memory entries (LB is
// its layer index width) and takes no item meanwhile; csr writes are taken as ever.
// A stalled rsp_ holds its result; the back end goes on until its next result
// is ready, and the queue and front end keep taking items until they fill.
module layer_vote_uv_map_accumulator_core
   import lvuv_pkg::*;
#(
   parameter int WIDTH      = DEF_WIDTH,
   parameter int HEIGHT     = DEF_HEIGHT,
   parameter int LAYERS     = DEF_LAYERS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pixel_x[8:0], pixel_y[17:9], layer[21:18], ray_level[28:22],
   // coord_u[42:29], coord_v[56:43], zero[63:57]
   input  logic [63:0] req_tdata,
   // mode[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // code_red[7:0], code_green[15:8], code_blue[23:16], label[28:24],
   // mixed[29], layer_count[34:30], zero[39:35]
   output logic [39:0] rsp_tdata
);

   cmd_type f_cmd, q_cmd;
   logic    f_valid, f_ready, q_valid, q_ready;
   rsp_type r;

   lvuv_front #(.WIDTH(WIDTH), .HEIGHT(HEIGHT), .LAYERS(LAYERS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .in_mode   (req_tuser),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_cmd   (f_cmd)
   );

   lvuv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_cmd    (f_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   lvuv_back #(.WIDTH(WIDTH), .HEIGHT(HEIGHT), .LAYERS(LAYERS),
               .COUNT_BITS(COUNT_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd       (q_cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (r)
   );

   assign rsp_tdata = {5'd0, r.layer_count, r.mixed, r.label,
                       r.code_blue, r.code_green, r.code_red};

endmodule

>>> hw/rtl/lvuv_front.sv
module lvuv_front
   import lvuv_pkg::*;
#(
   parameter int WIDTH  = DEF_WIDTH,
   parameter int HEIGHT = DEF_HEIGHT,
   parameter int LAYERS = DEF_LAYERS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_data,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [63:0]           in_data,
   input  logic                  in_mode,
   output logic                  out_valid,
   input  logic                  out_ready,
   output cmd_type               out_cmd
);

   logic                  enable_ff;
   logic [LAYER_BITS-1:0] highest_ff, highest_in;
   cmd_type               cmd_ff, cmd_in;
   logic                  valid_ff, valid_in;
   logic [XY_BITS-1:0]    px, py;
   logic [LAYER_BITS-1:0] lay;
   logic                  take, keep;

   assign csr_ready = 1'b1;
   assign px  = in_data[XY_BITS-1:0];
   assign py  = in_data[2*XY_BITS-1:XY_BITS];
   assign lay = in_data[2*XY_BITS+LAYER_BITS-1:2*XY_BITS];
   assign in_ready = !valid_ff || out_ready;
   assign take = in_valid && in_ready;
   assign keep = (in_mode == MODE_RESOLVE) || enable_ff;

   always_comb begin
      highest_in = highest_ff;
      if (take && in_mode == MODE_ACCUMULATE && enable_ff && lay > highest_ff) begin
         highest_in = lay;
      end
      cmd_in.mode        = mode_type'(in_mode);
      cmd_in.pixel_x     = px;
      cmd_in.pixel_y     = py;
      cmd_in.layer       = lay;
      cmd_in.ray_level   = in_data[2*XY_BITS+LAYER_BITS+RAY_BITS-1:2*XY_BITS+LAYER_BITS];
      cmd_in.coord_u     = in_data[2*XY_BITS+LAYER_BITS+RAY_BITS+COORD_BITS-1:
                                   2*XY_BITS+LAYER_BITS+RAY_BITS];
      cmd_in.coord_v     = in_data[2*XY_BITS+LAYER_BITS+RAY_BITS+2*COORD_BITS-1:
                                   2*XY_BITS+LAYER_BITS+RAY_BITS+COORD_BITS];
      cmd_in.in_frame    = (32'(px) < 32'(WIDTH)) && (32'(py) < 32'(HEIGHT));
      cmd_in.layer_ok    = 32'(lay) < 32'(LAYERS);
      cmd_in.layer_count = {1'b0, highest_in} + 5'd1;
      valid_in = valid_ff;
      if (out_ready) valid_in = 1'b0;
      if (take && keep) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         highest_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) enable_ff <= csr_data;
         highest_ff <= highest_in;
         valid_ff   <= valid_in;
      end
      if (take && keep) cmd_ff <= cmd_in;
   end

   assign out_valid = valid_ff;
   assign out_cmd   = cmd_ff;

endmodule

>>> hw/rtl/lvuv_queue.sv
module lvuv_queue
   import lvuv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);

   cmd_type    slot_ff [2];
   logic [1:0] fill_ff, fill_in;
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic       push, pop;

   assign in_ready  = fill_ff != 2'd2;
   assign out_valid = fill_ff != 2'd0;
   assign out_cmd   = slot_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      fill_in = fill_ff + 2'(push) - 2'(pop);
      wr_in   = wr_ff ^ push;
      rd_in   = rd_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
      end
      if (push) slot_ff[wr_ff] <= in_cmd;
   end

   `include "assert_macros.svh"
   `ASSERT_CLK(a_fill_range, clock, reset, fill_ff != 2'd3, "queue fill out of range")
   `ASSERT_CLK(a_fill_step, clock, reset, (push && !pop) |=> fill_ff == $past(fill_ff) + 2'd1,
               "queue fill did not follow a push")

endmodule

>>> hw/rtl/lvuv_divider.sv
module lvuv_divider
   import lvuv_pkg::*;
#(
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SUM_BITS-1:0] sum,
   input  logic [COUNT_BITS-1:0]   count,
   output logic                    done,
   output logic [CODE_BITS-1:0]    code
);

   localparam int NUM_BITS = SUM_BITS + COUNT_BITS + 16;
   localparam int QB = NUM_BITS;
   localparam int STEP_BITS = $clog2(QB + 1);

   logic [NUM_BITS-1:0]     rem_ff, rem_in;
   logic [NUM_BITS-1:0]     quo_ff, quo_in;
   logic [COUNT_BITS+1:0]   den_ff;
   logic [STEP_BITS-1:0]    step_ff, step_in;
   logic                    busy_ff, busy_in, neg_ff, done_ff, done_in;
   logic signed [NUM_BITS-1:0] num;
   logic [NUM_BITS:0]       trial;
   logic [NUM_BITS-1:0]     cval;

   assign num = (NUM_BITS'(sum) <<< 1) + $signed(NUM_BITS'(14'd8193) * NUM_BITS'(count));

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[NUM_BITS-1]};
      if (busy_ff) begin
         quo_in = {quo_ff[NUM_BITS-2:0], 1'b0};
         if (trial >= (NUM_BITS+1)'(den_ff)) begin
            rem_in = NUM_BITS'(trial - (NUM_BITS+1)'(den_ff));
            quo_in[0] = 1'b1;
         end else begin
            rem_in = NUM_BITS'(trial);
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         step_in = STEP_BITS'(QB);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      if (start) begin
         den_ff <= {1'b0, count, 1'b0};
         neg_ff <= num[NUM_BITS-1];
      end
   end

   always_comb begin
      cval = quo_ff;
      if (cval > NUM_BITS'(4095)) cval = cval - NUM_BITS'(4096);
      if (neg_ff) code = '0;
      else if (cval > NUM_BITS'(4095)) code = 12'd4095;
      else code = cval[CODE_BITS-1:0];
   end

   assign done = done_ff;

endmodule

>>> hw/rtl/lvuv_back.sv
module lvuv_back
   import lvuv_pkg::*;
#(
   parameter int WIDTH      = DEF_WIDTH,
   parameter int HEIGHT     = DEF_HEIGHT,
   parameter int LAYERS     = DEF_LAYERS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   localparam int PIXELS   = WIDTH * HEIGHT;
   localparam int PIX_BITS = $clog2(PIXELS);
   localparam int LB       = (LAYERS > 1) ? $clog2(LAYERS) : 1;
   localparam int ENT_BITS = PIX_BITS + LB;
   localparam int ENTRIES  = PIXELS << LB;
   localparam int TOT_BITS = COUNT_BITS + 5;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic signed [SUM_BITS-1:0] su_mem [ENTRIES];
   logic signed [SUM_BITS-1:0] sv_mem [ENTRIES];
   logic [COUNT_BITS-1:0]      ct_mem [ENTRIES];
   logic [RAY_BITS-1:0]        ray_mem [PIXELS];

   state_type state_ff, state_in;
   cmd_type   cur_ff;
   logic [ENT_BITS:0] sweep_ff, sweep_in;
   logic [LB:0]       k_ff, k_in;
   logic [LB-1:0]     win_ff, win_in;
   logic [COUNT_BITS-1:0] max_ff, max_in;
   logic [TOT_BITS-1:0]   tot_ff, tot_in;
   logic [CODE_BITS-1:0]  cu_ff;
   logic [PIX_BITS-1:0]   pix;
   logic [ENT_BITS-1:0]   raddr, waddr;
   logic signed [SUM_BITS-1:0] rd_su, rd_sv;
   logic [COUNT_BITS-1:0] rd_ct;
   logic [RAY_BITS-1:0]   rd_ray;
   logic we, ray_we;
   logic signed [SUM_BITS-1:0] wd_su, wd_sv;
   logic [COUNT_BITS-1:0] wd_ct;
   logic [RAY_BITS-1:0]   wd_ray;
   logic div_start, div_done;
   logic [CODE_BITS-1:0] div_code, cv;
   logic [TOT_BITS+5:0] lhs, rhs;
   rsp_type rsp_ff, rsp_in;
   rsp_type res_ff, res_in;
   logic    rv_ff, rv_in;

   assign pix = PIX_BITS'(32'(cur_ff.pixel_y) * WIDTH + 32'(cur_ff.pixel_x));

   always_ff @(posedge clock) begin
      rd_su  <= su_mem[raddr];
      rd_sv  <= sv_mem[raddr];
      rd_ct  <= ct_mem[raddr];
      rd_ray <= ray_mem[pix];
      if (we) begin
         su_mem[waddr] <= wd_su;
         sv_mem[waddr] <= wd_sv;
         ct_mem[waddr] <= wd_ct;
      end
      if (ray_we) ray_mem[waddr[ENT_BITS-1:LB]] <= wd_ray;
   end

   lvuv_divider #(.COUNT_BITS(COUNT_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .sum   ((state_ff == ST_DIV_U) ? rd_sv : rd_su),
      .count (max_ff),
      .done  (div_done),
      .code  (div_code)
   );

   assign cv   = 12'd4095 - div_code;
   assign lhs  = (TOT_BITS+6)'(max_ff) * (TOT_BITS+6)'(20);
   assign rhs  = (TOT_BITS+6)'(tot_ff) * (TOT_BITS+6)'(11);
   assign cmd_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      sweep_in  = sweep_ff;
      k_in      = k_ff;
      win_in    = win_ff;
      max_in    = max_ff;
      tot_in    = tot_ff;
      raddr     = {pix, k_ff[LB-1:0]};
      waddr     = {pix, k_ff[LB-1:0]};
      we        = 1'b0;
      ray_we    = 1'b0;
      wd_su     = '0;
      wd_sv     = '0;
      wd_ct     = '0;
      wd_ray    = RAY_RESET;
      div_start = 1'b0;
      rsp_in    = rsp_ff;
      res_in    = res_ff;
      rv_in     = rv_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            waddr  = sweep_ff[ENT_BITS-1:0];
            we     = 1'b1;
            ray_we = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == (ENT_BITS+1)'(ENTRIES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               k_in   = '0;
               max_in = '0;
               tot_in = '0;
               win_in = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            raddr = {pix, LB'(cur_ff.layer)};
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            raddr = {pix, LB'(cur_ff.layer)};
            if (cur_ff.mode == MODE_RESOLVE) begin
               state_in = cur_ff.in_frame ? ST_SCAN : ST_EMIT;
               raddr = {pix, k_ff[LB-1:0]};
            end else if (!cur_ff.in_frame || !cur_ff.layer_ok
                         || cur_ff.ray_level > rd_ray) begin
               state_in = ST_IDLE;
            end else if (cur_ff.ray_level < rd_ray) begin
               k_in = '0;
               state_in = ST_WIPE;
            end else begin
               state_in = ST_ACC;
            end
         end
         ST_WIPE: begin
            we = 1'b1;
            ray_we = 1'b1;
            wd_ray = cur_ff.ray_level;
            k_in = k_ff + 1'b1;
            if (32'(k_ff) == LAYERS - 1) begin
               state_in = (cur_ff.mode == MODE_RESOLVE) ? ST_EMIT : ST_READ;
            end
         end
         ST_ACC: begin
            waddr = {pix, LB'(cur_ff.layer)};
            if (rd_ct != COUNT_MAX) begin
               we = 1'b1;
               wd_su = rd_su + SUM_BITS'($signed(cur_ff.coord_u));
               wd_sv = rd_sv + SUM_BITS'($signed(cur_ff.coord_v));
               wd_ct = rd_ct + 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            // Read data for layer k_ff is registered, arriving in the cycle after its address.
            if (rd_ct > max_ff) begin
               max_in = rd_ct;
               win_in = k_ff[LB-1:0];
            end
            tot_in = tot_ff + TOT_BITS'(rd_ct);
            k_in = k_ff + 1'b1;
            if (32'(k_ff) == LAYERS - 1) begin
               raddr = {pix, win_in};
               state_in = ST_MAJ;
            end else begin
               raddr = {pix, k_ff[LB-1:0] + 1'b1};
               state_in = ST_WAIT;
            end
         end
         ST_MAJ: begin
            raddr = {pix, win_ff};
            res_in.code_red   = 8'd255;
            res_in.code_green = 8'd255;
            res_in.code_blue  = 8'd255;
            res_in.label      = '0;
            res_in.mixed      = 1'b0;
            if (tot_ff == '0) begin
               k_in = '0;
               state_in = ST_WIPE;
            end else if (lhs > rhs) begin
               state_in = ST_DIV_U;
               div_start = 1'b1;
            end else begin
               res_in.mixed = 1'b1;
               k_in = '0;
               state_in = ST_WIPE;
            end
         end
         ST_DIV_U: begin
            raddr = {pix, win_ff};
            if (div_done) begin
               div_start = 1'b1;
               state_in  = ST_DIV_V;
            end
         end
         ST_DIV_V: begin
            raddr = {pix, win_ff};
            if (div_done) begin
               res_in.code_red   = cu_ff[7:0];
               res_in.code_green = cv[7:0];
               res_in.code_blue  = {cv[11:8], cu_ff[11:8]};
               res_in.label      = 5'(win_ff) + 5'd1;
               k_in = '0;
               state_in = ST_WIPE;
            end
         end
         ST_EMIT: begin
            if (!rv_ff || rsp_ready) begin
               rsp_in = res_ff;
               if (!cur_ff.in_frame) begin
                  rsp_in.code_red   = 8'd255;
                  rsp_in.code_green = 8'd255;
                  rsp_in.code_blue  = 8'd255;
                  rsp_in.label      = '0;
                  rsp_in.mixed      = 1'b0;
               end
               rsp_in.layer_count = cur_ff.layer_count;
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_WIPE && cur_ff.mode == MODE_RESOLVE) wd_ray = RAY_RESET;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         sweep_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         rv_ff    <= rv_in;
      end
      k_ff   <= k_in;
      win_ff <= win_in;
      max_ff <= max_in;
      tot_ff <= tot_in;
      rsp_ff <= rsp_in;
      res_ff <= res_in;
      if (state_ff == ST_DIV_U && div_done) cu_ff <= div_code;
      if (cmd_valid && cmd_ready) cur_ff <= cmd;
   end

   assign rsp_valid = rv_ff;
   assign rsp       = rsp_ff;

   `include "assert_macros.svh"
   `ASSERT_CLK(a_no_take_busy, clock, reset, (cmd_valid && cmd_ready) |-> state_ff == ST_IDLE,
               "command taken while busy")
   `ASSERT_CLK(a_rsp_hold, clock, reset, (rv_ff && !rsp_ready) |=> rv_ff,
               "response dropped while stalled")
   `ASSERT_CLK(a_reset_clear, clock, reset, $past(reset) |-> state_ff == ST_CLEAR,
               "reset did not start clearing")

endmodule
